// ===== sv/assert_macros.svh =====
// ---------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion shorthands, sampled on clk and quiet while arst_n is low
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define VCLW_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("vclw assertion failed");

// next-cycle implication
`define VCLW_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("vclw assertion failed");

`endif

// ===== sv/vclw_pkg.sv =====
// ---------------------------------------------------------------------------
// vclw_pkg
// shared types and constants of the vertex color lift-to-white unit
// ---------------------------------------------------------------------------
`default_nettype none

package vclw_pkg;

	// color format codes
	localparam logic [2:0] FMT_RGBA8  = 3'd0;
	localparam logic [2:0] FMT_RGBX8  = 3'd1;
	localparam logic [2:0] FMT_RGB8   = 3'd2;
	localparam logic [2:0] FMT_RGB565 = 3'd3;
	localparam logic [2:0] FMT_RGBA4  = 3'd4;
	localparam logic [2:0] FMT_RGBA6  = 3'd5;

	// element sizes in bytes
	localparam logic [3:0] SIZE_4B = 4'd4;
	localparam logic [3:0] SIZE_3B = 4'd3;
	localparam logic [3:0] SIZE_2B = 4'd2;

	// channel full-scale values
	localparam logic [7:0] FULL_8B = 8'd255;
	localparam logic [7:0] FULL_6B = 8'd63;
	localparam logic [7:0] FULL_5B = 8'd31;
	localparam logic [7:0] FULL_4B = 8'd15;

	localparam logic [6:0] PCT_FULL = 7'd100;
	localparam logic [14:0] ROUND_HALF = 15'd50;

	// floor(x/100) == (x*5243) >> 19 for every x below 25600
	localparam int          RECIP_SHIFT = 19;
	localparam logic [12:0] RECIP_100   = 13'd5243;

	localparam int NUM_CHAN = 3;

	typedef logic [7:0]  chan_t;
	typedef logic [14:0] wsum_t;

	typedef struct packed {
		logic lift;
		logic skip;
	} ctrl_t;

endpackage

`default_nettype wire

// ===== sv/vclw_front.sv =====
// ---------------------------------------------------------------------------
// vclw_front
// format decode, channel extraction and weighted sums per channel
// ---------------------------------------------------------------------------
`default_nettype none

module vclw_front (
	input  wire logic [2:0]    color_format,
	input  wire logic [3:0]    element_stride,
	input  wire logic [31:0]   color_word,
	input  wire logic [6:0]    pct,
	output vclw_pkg::ctrl_t    ctrl,
	output vclw_pkg::chan_t    full [vclw_pkg::NUM_CHAN],
	output vclw_pkg::wsum_t    wsum [vclw_pkg::NUM_CHAN]
);

	logic            known;
	logic [3:0]      need;
	vclw_pkg::chan_t v [vclw_pkg::NUM_CHAN];
	logic [6:0]      pct_inv;

	always_comb begin
		known = 1'b1;
		need  = vclw_pkg::SIZE_4B;
		for (int i = 0; i < vclw_pkg::NUM_CHAN; i++) begin
			v[i]    = '0;
			full[i] = vclw_pkg::FULL_8B;
		end
		unique case (color_format)
			vclw_pkg::FMT_RGBA8, vclw_pkg::FMT_RGBX8: begin
				v[0] = color_word[31:24];
				v[1] = color_word[23:16];
				v[2] = color_word[15:8];
			end
			vclw_pkg::FMT_RGB8: begin
				need = vclw_pkg::SIZE_3B;
				v[0] = color_word[23:16];
				v[1] = color_word[15:8];
				v[2] = color_word[7:0];
			end
			vclw_pkg::FMT_RGB565: begin
				need    = vclw_pkg::SIZE_2B;
				v[0]    = {3'b000, color_word[15:11]};
				v[1]    = {2'b00, color_word[10:5]};
				v[2]    = {3'b000, color_word[4:0]};
				full[0] = vclw_pkg::FULL_5B;
				full[1] = vclw_pkg::FULL_6B;
				full[2] = vclw_pkg::FULL_5B;
			end
			vclw_pkg::FMT_RGBA4: begin
				need = vclw_pkg::SIZE_2B;
				v[0] = {4'h0, color_word[15:12]};
				v[1] = {4'h0, color_word[11:8]};
				v[2] = {4'h0, color_word[7:4]};
				for (int i = 0; i < vclw_pkg::NUM_CHAN; i++) full[i] = vclw_pkg::FULL_4B;
			end
			vclw_pkg::FMT_RGBA6: begin
				need = vclw_pkg::SIZE_3B;
				v[0] = {2'b00, color_word[23:18]};
				v[1] = {2'b00, color_word[17:12]};
				v[2] = {2'b00, color_word[11:6]};
				for (int i = 0; i < vclw_pkg::NUM_CHAN; i++) full[i] = vclw_pkg::FULL_6B;
			end
			default: begin
				known = 1'b0;
			end
		endcase
	end

	assign ctrl.skip = known && (element_stride != need);
	assign ctrl.lift = known && (element_stride == need);
	assign pct_inv   = vclw_pkg::PCT_FULL - pct;

	// full*(100-p) + v*p + 50, at most 25550
	always_comb begin
		for (int i = 0; i < vclw_pkg::NUM_CHAN; i++) begin
			wsum[i] = ({7'd0, full[i]} * {8'd0, pct_inv})
				+ ({7'd0, v[i]} * {8'd0, pct})
				+ vclw_pkg::ROUND_HALF;
		end
	end

endmodule

`default_nettype wire

// ===== sv/vclw_back.sv =====
// ---------------------------------------------------------------------------
// vclw_back
// divide by one hundred, clamp to full scale and repack the word
// ---------------------------------------------------------------------------
`default_nettype none

module vclw_back (
	input  wire logic [2:0]     color_format,
	input  wire logic [31:0]    color_word,
	input  wire vclw_pkg::ctrl_t ctrl,
	input  wire vclw_pkg::chan_t full [vclw_pkg::NUM_CHAN],
	input  wire vclw_pkg::wsum_t wsum [vclw_pkg::NUM_CHAN],
	output logic [31:0]         color_res
);

	logic [27:0]     prod [vclw_pkg::NUM_CHAN];
	vclw_pkg::chan_t quo  [vclw_pkg::NUM_CHAN];
	vclw_pkg::chan_t n    [vclw_pkg::NUM_CHAN];

	always_comb begin
		for (int i = 0; i < vclw_pkg::NUM_CHAN; i++) begin
			prod[i] = {13'd0, wsum[i]} * {15'd0, vclw_pkg::RECIP_100};
			quo[i]  = prod[i][vclw_pkg::RECIP_SHIFT +: 8];
			n[i]    = (quo[i] > full[i]) ? full[i] : quo[i];
		end
	end

	always_comb begin
		color_res = color_word;
		if (ctrl.lift) begin
			unique case (color_format)
				vclw_pkg::FMT_RGBA8, vclw_pkg::FMT_RGBX8: begin
					color_res[31:8] = {n[0], n[1], n[2]};
				end
				vclw_pkg::FMT_RGB8: begin
					color_res[23:0] = {n[0], n[1], n[2]};
				end
				vclw_pkg::FMT_RGB565: begin
					color_res[15:0] = {n[0][4:0], n[1][5:0], n[2][4:0]};
				end
				vclw_pkg::FMT_RGBA4: begin
					color_res[15:4] = {n[0][3:0], n[1][3:0], n[2][3:0]};
				end
				vclw_pkg::FMT_RGBA6: begin
					color_res[23:6] = {n[0][5:0], n[1][5:0], n[2][5:0]};
				end
				default: begin
					color_res = color_word;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

// ===== sv/vertex_color_lift_to_white_unit.sv =====
// ---------------------------------------------------------------------------
// vertex_color_lift_to_white_unit
// lifts the r, g and b channels of one packed vertex color toward white
// ---------------------------------------------------------------------------
// usage
//   input beat: a color element (format, stride, word, last flag) is taken at
//   a rising edge with start high and busy low; busy is always low, so a beat
//   may be offered every cycle
//   result beat: color_out, stride_skipped and last_out are valid for exactly
//   one cycle while done is high; the receiver has no way to hold them off
//   pipeline: a taken beat passes three register stages (input, weighted
//   sum, result) before done shows it
//   throughput: one beat per cycle, as busy never rises; the multiplies sit
//   between the stages (weighted sums, then reciprocal divide by 100)
//   config: keep_percent is written at an edge with keep_percent_we high;
//   only write while no beat is in flight; values above 100 act as 100
//   reset: arst_n low empties the pipeline and sets keep_percent to 100,
//   so colors pass unchanged until it is written
// ---------------------------------------------------------------------------
`default_nettype none

module vertex_color_lift_to_white_unit (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// config
	input  wire logic        keep_percent_we,
	input  wire logic [6:0]  keep_percent,
	// input beat
	input  wire logic        start,
	output logic             busy,
	input  wire logic [2:0]  color_format,
	input  wire logic [3:0]  element_stride,
	input  wire logic [31:0] color_word,
	input  wire logic        last_in,
	// result beat
	output logic             done,
	output logic [31:0]      color_out,
	output logic             stride_skipped,
	output logic             last_out
);

	// kept-lighting percent register
	logic [6:0] keep_pct_q;

	// stage 1: raw input beat plus clamped percent
	logic        valid_s1;
	logic [2:0]  fmt_s1;
	logic [3:0]  stride_s1;
	logic [31:0] word_s1;
	logic        last_s1;
	logic [6:0]  pct_s1;

	// stage 2: decoded control and per-channel weighted sums
	logic                valid_s2;
	logic [2:0]          fmt_s2;
	logic [31:0]         word_s2;
	logic                last_s2;
	vclw_pkg::ctrl_t     ctrl_s2;
	vclw_pkg::chan_t     full_s2 [vclw_pkg::NUM_CHAN];
	vclw_pkg::wsum_t     wsum_s2 [vclw_pkg::NUM_CHAN];

	// stage 3: result registers driving the ports
	logic        valid_s3;
	logic [31:0] color_s3;
	logic        skip_s3;
	logic        last_s3;

	logic            accept;
	logic [6:0]      pct_clamped;
	vclw_pkg::ctrl_t ctrl_c;
	vclw_pkg::chan_t full_c [vclw_pkg::NUM_CHAN];
	vclw_pkg::wsum_t wsum_c [vclw_pkg::NUM_CHAN];
	logic [31:0]     color_c;

	// pipeline never stalls
	assign busy   = 1'b0;
	assign accept = start && !busy;

	assign pct_clamped = (keep_pct_q > vclw_pkg::PCT_FULL) ? vclw_pkg::PCT_FULL : keep_pct_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			keep_pct_q <= vclw_pkg::PCT_FULL;
		end else if (keep_percent_we) begin
			keep_pct_q <= keep_percent;
		end
	end

	// valid chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			valid_s1 <= accept;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	// stage 1 payload
	always_ff @(posedge clk) begin
		if (accept) begin
			fmt_s1    <= color_format;
			stride_s1 <= element_stride;
			word_s1   <= color_word;
			last_s1   <= last_in;
			pct_s1    <= pct_clamped;
		end
	end

	// decode, extract and weigh
	vclw_front u_front (
		.color_format   (fmt_s1),
		.element_stride (stride_s1),
		.color_word     (word_s1),
		.pct            (pct_s1),
		.ctrl           (ctrl_c),
		.full           (full_c),
		.wsum           (wsum_c)
	);

	// stage 2 payload
	always_ff @(posedge clk) begin
		if (valid_s1) begin
			fmt_s2  <= fmt_s1;
			word_s2 <= word_s1;
			last_s2 <= last_s1;
			ctrl_s2 <= ctrl_c;
			full_s2 <= full_c;
			wsum_s2 <= wsum_c;
		end
	end

	// divide, clamp and repack
	vclw_back u_back (
		.color_format (fmt_s2),
		.color_word   (word_s2),
		.ctrl         (ctrl_s2),
		.full         (full_s2),
		.wsum         (wsum_s2),
		.color_res    (color_c)
	);

	// stage 3 payload
	always_ff @(posedge clk) begin
		if (valid_s2) begin
			color_s3 <= color_c;
			skip_s3  <= ctrl_s2.skip;
			last_s3  <= last_s2;
		end
	end

	assign done           = valid_s3;
	assign color_out      = color_s3;
	assign stride_skipped = skip_s3;
	assign last_out       = last_s3;

	// checks
	`include "assert_macros.svh"

	// every accepted beat is followed by done
	`VCLW_ASSERT_IMP(a_beat_out, accept, ##3 done)
	// no result beat without an input beat
	`VCLW_ASSERT_IMP(a_no_spurious, done, $past(accept, 3))
	// a skipped element leaves the word untouched
	`VCLW_ASSERT_IMP(a_skip_pass, done && stride_skipped, color_out == $past(color_word, 3))
	// lift and skip never both decoded for one beat
	`VCLW_ASSERT_NXT(a_ctrl_excl, valid_s1, !(ctrl_s2.lift && ctrl_s2.skip))

endmodule

`default_nettype wire
